// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque package
// Sizes, operation and status codes, and the command passed from the
// request classifier to the storage engine.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int CAPACITY    = 1024;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   localparam int KIND_WIDTH   = 2;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int OCC_WIDTH    = 11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_POP_FRONT  = 2'd1,
      KIND_PUSH_BACK  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                  wr;
      logic                  rd;
      logic [ADDR_WIDTH-1:0] addr;
      logic [DATA_WIDTH-1:0] data;
      status_type            status;
      logic [OCC_WIDTH-1:0]  occupancy;
   } cmd_type;

endpackage

// ===== rtl/rbd_req_if.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque request channel
// Valid/ready channel carrying one deque operation per beat.
// ----------------------------------------------------------------------------
interface rbd_req_if;
   import rbd_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [KIND_WIDTH-1:0]          kind;
   logic signed [VALUE_WIDTH-1:0]  push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);

endinterface

// ===== rtl/rbd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface rbd_rsp_if;
   import rbd_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [VALUE_WIDTH-1:0]  pop_value;
   logic [STATUS_WIDTH-1:0]        status;
   logic [OCC_WIDTH-1:0]           occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);

endinterface

// ===== rtl/rbd_front.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque request classifier
// Checks each request against the element count, keeps the front and back
// pointers and the count, and issues a store command for the storage engine.
// ----------------------------------------------------------------------------
module rbd_front (
   input  logic             clock,
   input  logic             reset,
   rbd_req_if.sink          req,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output rbd_pkg::cmd_type cmd
);
   import rbd_pkg::*;

   logic [ADDR_WIDTH-1:0]  front_ff, front_in;
   logic [ADDR_WIDTH-1:0]  back_ff, back_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [ADDR_WIDTH-1:0]  front_dec, front_inc, back_dec, back_inc;
   logic                   full, empty, accept;
   logic [63:0]            value_ext, count_ext;
   kind_type               kind;

   assign front_inc = (front_ff == ADDR_WIDTH'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? ADDR_WIDTH'(CAPACITY - 1) : front_ff - 1'b1;
   assign back_inc  = (back_ff == ADDR_WIDTH'(CAPACITY - 1)) ? '0 : back_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? ADDR_WIDTH'(CAPACITY - 1) : back_ff - 1'b1;

   assign full  = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign empty = (count_ff == '0);
   assign kind  = kind_type'(req.kind);

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;
   assign accept    = req.valid && cmd_ready;

   assign value_ext = {32'b0, req.push_value};
   assign count_ext = 64'(count_in);

   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      cmd.wr        = 1'b0;
      cmd.rd        = 1'b0;
      cmd.addr      = front_ff;
      cmd.data      = value_ext[DATA_WIDTH-1:0];
      cmd.status    = STATUS_DONE;
      unique case (kind)
         KIND_PUSH_FRONT: begin
            if (full) begin
               cmd.status = STATUS_FULL;
            end else begin
               front_in = front_dec;
               cmd.wr   = 1'b1;
               cmd.addr = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_PUSH_BACK: begin
            if (full) begin
               cmd.status = STATUS_FULL;
            end else begin
               back_in  = back_inc;
               cmd.wr   = 1'b1;
               cmd.addr = back_ff;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            if (empty) begin
               cmd.status = STATUS_EMPTY;
            end else begin
               front_in = front_inc;
               cmd.rd   = 1'b1;
               cmd.addr = front_ff;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            if (empty) begin
               cmd.status = STATUS_EMPTY;
            end else begin
               back_in  = back_dec;
               cmd.rd   = 1'b1;
               cmd.addr = back_dec;
               count_in = count_ff - 1'b1;
            end
         end
      endcase
      cmd.occupancy = count_ext[OCC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/rbd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque command queue
// Short first-in first-out queue that decouples the classifier from the
// storage engine.
// ----------------------------------------------------------------------------
module rbd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rbd_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output rbd_pkg::cmd_type out_cmd
);
   import rbd_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_WIDTH-1:0]  count_ff;
   logic                   push, pop;

   assign in_ready  = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/rbd_back.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque storage engine
// Holds the element store, carries out writes and reads in command order,
// and registers one response beat.
// ----------------------------------------------------------------------------
module rbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  rbd_pkg::cmd_type cmd,
   rbd_rsp_if.source        rsp
);
   import rbd_pkg::*;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  is_read_ff;
   status_type            status_ff;
   logic [OCC_WIDTH-1:0]  occ_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  take;
   logic [63:0]           pop_ext;

   assign cmd_ready    = !rsp_valid_ff || rsp.ready;
   assign take         = cmd_valid && cmd_ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (take && cmd.wr) begin
         mem[cmd.addr] <= cmd.data;
      end
      if (take && cmd.rd) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         is_read_ff <= cmd.rd;
         status_ff  <= cmd.status;
         occ_ff     <= cmd.occupancy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign pop_ext       = 64'(rd_data_ff);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pop_value = is_read_ff ? signed'(pop_ext[VALUE_WIDTH-1:0]) : '0;
   assign rsp.status    = status_ff;
   assign rsp.occupancy = occ_ff;

endmodule

// ===== rtl/ring_buffer_deque_top.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque
// Double-ended queue of words in a circular store with wrapping front and
// back pointers and an element count.
//
//   Channel   Direction   Beat contents
//   req       in          kind, push_value
//   rsp       out         pop_value, status, occupancy
//
// One request per cycle is accepted while the response side is not stalled;
// each gives one response beat, through the command queue and the response register.
// The store is a single-port synchronous memory; pops read it through a
// registered read port.
// Reset clears the pointers, the count, the command queue and the response
// valid flag only.
// A stalled response fills the two-entry command queue, after which
// req.ready drops until the response side drains.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top (
   input logic       clock,
   input logic       reset,
   rbd_req_if.sink   req,
   rbd_rsp_if.source rsp
);
   import rbd_pkg::*;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    back_valid, back_ready;
   cmd_type back_cmd;

   rbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   rbd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   rbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp       (rsp)
   );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ring buffer deque testbench
// Sends push and pop requests at both ends of the deque through the request
// channel. A small deque model in the bench predicts the popped value,
// status and occupancy of every response beat, and the monitor compares
// each beat field by field. The run covers empty pops, filling to capacity,
// pushes on a full queue and pointer wrap at both ends. The sender idles in
// bursts and the receiver stalls on a separate pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import rbd_pkg::*;

   localparam int OP_LIMIT = 8192;

   typedef struct {
      kind_type                       kind;
      logic signed [VALUE_WIDTH-1:0]  value;
   } deque_op_type;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0]  pop_value;
      status_type                     status;
      logic [OCC_WIDTH-1:0]           occupancy;
   } deque_result_type;

   logic clock;
   logic reset;

   rbd_req_if req_ch ();
   rbd_rsp_if rsp_ch ();

   ring_buffer_deque_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   deque_op_type     pending_ops [OP_LIMIT];
   int               pending_head = 0;
   int               pending_tail = 0;
   deque_result_type expected_results [OP_LIMIT];
   int               expect_head = 0;
   int               expect_tail = 0;

   logic [DATA_WIDTH-1:0]  model_store [CAPACITY];
   logic [ADDR_WIDTH-1:0]  model_front = '0;
   logic [ADDR_WIDTH-1:0]  model_back  = '0;
   logic [COUNT_WIDTH-1:0] model_count = '0;

   int error_count = 0;
   int gen_level   = 0;

   int sender_burst = 0;
   int sender_idle  = 0;
   int sink_hold    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_POP_FRONT;
      req_ch.push_value = '0;
      rsp_ch.ready      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < 100) begin
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   function automatic deque_result_type deque_apply(input deque_op_type op);
      deque_result_type res;
      res.pop_value = '0;
      res.status    = STATUS_DONE;
      case (op.kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (model_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else if (op.kind == KIND_PUSH_FRONT) begin
               model_front = (model_front == '0) ? ADDR_WIDTH'(CAPACITY - 1)
                                                 : model_front - 1'b1;
               model_store[model_front] = op.value[DATA_WIDTH-1:0];
               model_count++;
            end else begin
               model_store[model_back] = op.value[DATA_WIDTH-1:0];
               model_back = (model_back == ADDR_WIDTH'(CAPACITY - 1)) ? '0
                                                                      : model_back + 1'b1;
               model_count++;
            end
         end
         default: begin
            if (model_count == '0) begin
               res.status = STATUS_EMPTY;
            end else if (op.kind == KIND_POP_FRONT) begin
               res.pop_value = VALUE_WIDTH'(model_store[model_front]);
               model_front = (model_front == ADDR_WIDTH'(CAPACITY - 1)) ? '0
                                                                        : model_front + 1'b1;
               model_count--;
            end else begin
               model_back = (model_back == '0) ? ADDR_WIDTH'(CAPACITY - 1)
                                               : model_back - 1'b1;
               res.pop_value = VALUE_WIDTH'(model_store[model_back]);
               model_count--;
            end
         end
      endcase
      res.occupancy = OCC_WIDTH'(model_count);
      return res;
   endfunction

   function automatic void queue_op(input kind_type kind, input logic [VALUE_WIDTH-1:0] value);
      deque_op_type op;
      op.kind  = kind;
      op.value = value;
      if (pending_tail < OP_LIMIT) begin
         pending_ops[pending_tail] = op;
         pending_tail++;
         if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
            if (gen_level < CAPACITY) gen_level++;
         end else if (gen_level > 0) begin
            gen_level--;
         end
      end
   endfunction

   function automatic void queue_random(input int push_pct);
      logic front_end;
      front_end = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < push_pct) begin
         queue_op(front_end ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom);
      end else begin
         queue_op(front_end ? KIND_POP_FRONT : KIND_POP_BACK, $urandom);
      end
   endfunction

   always @(posedge clock) begin
      deque_op_type op;
      if (reset) begin
         req_ch.valid <= 1'b0;
         sender_burst = $urandom_range(1, 32);
         sender_idle  = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            op.kind  = kind_type'(req_ch.kind);
            op.value = req_ch.push_value;
            expected_results[expect_tail] = deque_apply(op);
            expect_tail++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (sender_idle > 0) begin
               sender_idle--;
               req_ch.valid <= 1'b0;
            end else if (pending_head < pending_tail) begin
               op = pending_ops[pending_head];
               pending_head++;
               req_ch.valid      <= 1'b1;
               req_ch.kind       <= op.kind;
               req_ch.push_value <= op.value;
               sender_burst--;
               if (sender_burst <= 0) begin
                  sender_burst = $urandom_range(1, 32);
                  sender_idle  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      logic level;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_hold = 0;
      end else if (sink_hold > 0) begin
         sink_hold--;
      end else begin
         level = ($urandom_range(0, 3) != 0);
         sink_hold = level ? $urandom_range(1, 40) : $urandom_range(1, 12);
         rsp_ch.ready <= level;
      end
   end

   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expect_head >= expect_tail) begin
            report_mismatch("unexpected beat, status", rsp_ch.status, -1);
         end else begin
            want = expected_results[expect_head];
            expect_head++;
            if (rsp_ch.pop_value !== want.pop_value)
               report_mismatch("pop_value", rsp_ch.pop_value, want.pop_value);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.occupancy !== want.occupancy)
               report_mismatch("occupancy", rsp_ch.occupancy, want.occupancy);
         end
      end
   end

   initial begin
      queue_op(KIND_POP_FRONT, 32'h1234_5678);
      queue_op(KIND_POP_BACK, 32'hFFFF_FFFF);
      queue_op(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_op(KIND_PUSH_BACK, 32'h8000_0000);
      queue_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
      queue_op(KIND_PUSH_BACK, 32'h0000_0000);
      queue_op(KIND_PUSH_FRONT, 32'h5555_5555);
      queue_op(KIND_PUSH_BACK, 32'hAAAA_AAAA);
      queue_op(KIND_POP_FRONT, 32'h0);
      queue_op(KIND_POP_BACK, 32'h0);
      queue_op(KIND_POP_BACK, 32'hFFFF_FFFF);
      queue_op(KIND_POP_FRONT, 32'h0);
      queue_op(KIND_POP_FRONT, 32'h0);
      queue_op(KIND_POP_BACK, 32'h0);
      queue_op(KIND_POP_FRONT, 32'h0);
      queue_op(KIND_POP_BACK, 32'h0);
      queue_op(KIND_PUSH_BACK, 32'h0000_0001);
      queue_op(KIND_POP_FRONT, 32'h0);
      queue_op(KIND_PUSH_FRONT, 32'hFFFF_FFFE);
      queue_op(KIND_POP_BACK, 32'h0);

      // Hover near empty, then fill to capacity and hover near full.
      repeat (150) queue_random(50);
      while (gen_level < CAPACITY && pending_tail < OP_LIMIT) queue_random(90);
      repeat (150) queue_random(55);
      repeat (100) queue_random(15);

      wait (!reset);
      while (pending_head < pending_tail || req_ch.valid || expect_head < expect_tail)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (expect_head != expect_tail)
         report_mismatch("results never received", expect_tail - expect_head, 0);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== ring_buffer_deque_top.f =====
rtl/rbd_pkg.sv
rtl/rbd_req_if.sv
rtl/rbd_rsp_if.sv
rtl/rbd_front.sv
rtl/rbd_cmd_queue.sv
rtl/rbd_back.sv
rtl/ring_buffer_deque_top.sv
test/tb_top.sv
